// File: rtl/core/dnr_pkg.sv
// ============================================================================
// dnr_pkg - shared types and constants of the Newton-Raphson divider
// Holds the unpacked float word, the per-item side word, the word handed from
// cell to cell, the iteration count and the stage latencies.
// ============================================================================
package dnr_pkg;

    // Newton-Raphson steps, one cell each
    localparam int unsigned ITERATIONS = 4;

    // Stage latencies of the arithmetic units
    localparam int unsigned FMUL_LAT  = 4;
    localparam int unsigned FSUB_LAT  = 2;
    localparam int unsigned INIT_LAT  = FMUL_LAT + FSUB_LAT;
    localparam int unsigned CELL_LAT  = 2 * FMUL_LAT + FSUB_LAT;

    // Delay of the old estimate inside a cell, up to the second multiply
    localparam int unsigned X_LAT     = FMUL_LAT + FSUB_LAT;

    // Largest leading-zero step of the dividend normalizer
    localparam int unsigned NORM_TOP  = 32;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [10:0] EXP_HALF     = 11'd1022;

    // Unpacked positive float: value = sig * 2^(exp - 1023 - 52)
    typedef struct packed {
        logic signed [12:0] exp;
        logic [52:0]        sig;
    } fp_t;

    // Dividend data that rides along with the reciprocal
    typedef struct packed {
        logic        sign;
        logic        force_en;
        logic [62:0] force_mag;
        fp_t         a;
    } side_t;

    // Word handed from one cell to the next
    typedef struct packed {
        logic  valid;
        fp_t   d;
        fp_t   x;
        side_t side;
    } cell_t;

    // Estimate constants and the Newton-Raphson constant two
    localparam fp_t C0  = '{exp: 13'sd1024, sig: {1'b1, 52'h69696A0000000}};
    localparam fp_t C1  = '{exp: 13'sd1023, sig: {1'b1, 52'hE1E1E20000000}};
    localparam fp_t TWO = '{exp: 13'sd1024, sig: {1'b1, 52'h0000000000000}};

    // Unpack a normal positive magnitude
    function automatic fp_t unpack_mag(input logic [62:0] mag);
        fp_t r;
        r.exp = $signed({2'b00, mag[62:52]});
        r.sig = {1'b1, mag[51:0]};
        return r;
    endfunction

endpackage

// File: rtl/core/dnr_fmul.sv
// ============================================================================
// dnr_fmul - four-stage double multiply, round to nearest even
// Splits the 53-bit significands into halves, sums the partial products,
// normalizes, denormalizes small results and rounds. Overflow gives infinity.
// ============================================================================
module dnr_fmul (
    input  logic            aclk,
    input  logic            en,
    input  dnr_pkg::fp_t    op_a,
    input  dnr_pkg::fp_t    op_b,
    output logic [62:0]     mag
);

    logic [51:0]        pp_hh_reg;
    logic [52:0]        pp_hl_reg;
    logic [52:0]        pp_lh_reg;
    logic [53:0]        pp_ll_reg;
    logic signed [13:0] e1_reg;

    logic [105:0]       prod_reg;
    logic signed [13:0] e2_reg;

    logic [105:0]       sh_reg;
    logic               stk_reg;
    logic signed [13:0] expn_reg;

    logic [62:0]        mag_reg;

    logic signed [13:0] e_sum;
    logic [53:0]        mid;
    logic [105:0]       prod_next;
    logic [105:0]       nrm;
    logic [105:0]       mask;
    logic signed [13:0] e_n;
    logic signed [13:0] rs_dist;
    logic [6:0]         amt;
    logic [52:0]        sg;
    logic               g;
    logic               st;
    logic               rnd;
    logic [53:0]        sum;
    logic [10:0]        base;
    logic [63:0]        pk_sum;
    logic [62:0]        mag_next;

    // Stage 1: partial products and exponent sum
    assign e_sum = $signed({op_a.exp[12], op_a.exp}) + $signed({op_b.exp[12], op_b.exp})
                   - 14'sd1023;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_hh_reg <= {26'b0, op_a.sig[52:27]} * {26'b0, op_b.sig[52:27]};
            pp_hl_reg <= {27'b0, op_a.sig[52:27]} * {26'b0, op_b.sig[26:0]};
            pp_lh_reg <= {26'b0, op_a.sig[26:0]} * {27'b0, op_b.sig[52:27]};
            pp_ll_reg <= {27'b0, op_a.sig[26:0]} * {27'b0, op_b.sig[26:0]};
            e1_reg    <= e_sum;
        end
    end

    // Stage 2: sum the partial products
    assign mid       = {1'b0, pp_hl_reg} + {1'b0, pp_lh_reg};
    assign prod_next = {pp_hh_reg, 54'b0} + {25'b0, mid, 27'b0} + {52'b0, pp_ll_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            e2_reg   <= e1_reg;
        end
    end

    // Stage 3: normalize, shift right into the subnormal range
    always_comb begin
        nrm     = prod_reg[105] ? prod_reg : {prod_reg[104:0], 1'b0};
        e_n     = prod_reg[105] ? e2_reg + 14'sd1 : e2_reg;
        rs_dist = 14'sd1 - e_n;
        if (e_n >= 14'sd1) begin
            amt = '0;
        end else if (rs_dist > 14'sd127) begin
            amt = 7'd127;
        end else begin
            amt = rs_dist[6:0];
        end
        mask = ~({106{1'b1}} << amt);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sh_reg   <= nrm >> amt;
            stk_reg  <= |(nrm & mask);
            expn_reg <= e_n;
        end
    end

    // Stage 4: round to nearest even and pack
    always_comb begin
        sg     = sh_reg[105:53];
        g      = sh_reg[52];
        st     = stk_reg | (|sh_reg[51:0]);
        rnd    = g & (st | sg[0]);
        sum    = {1'b0, sg} + {53'b0, rnd};
        base   = (expn_reg >= 14'sd1) ? 11'(expn_reg - 14'sd1) : 11'd0;
        pk_sum = {1'b0, base, 52'b0} + {10'b0, sum};
        if (expn_reg >= 14'sd2047) begin
            mag_next = {dnr_pkg::EXP_ALL_ONES, 52'b0};
        end else begin
            mag_next = pk_sum[62:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

// File: rtl/core/dnr_fsub.sv
// ============================================================================
// dnr_fsub - two-stage double subtract of positive operands, a above b
// Aligns b by the low two bits of the exponent difference (at most three places),
// subtracts, renormalizes by up to two places and rounds to nearest even.
// ============================================================================
module dnr_fsub (
    input  logic            aclk,
    input  logic            en,
    input  dnr_pkg::fp_t    op_a,
    input  dnr_pkg::fp_t    op_b,
    output logic [62:0]     mag
);

    logic [54:0]        rem_reg;
    logic signed [12:0] ea_reg;
    logic [62:0]        mag_reg;

    logic signed [12:0] dif;
    logic [54:0]        bal;
    logic [52:0]        sg;
    logic               g;
    logic               st;
    logic               rnd;
    logic signed [12:0] e;
    logic [53:0]        sum;
    logic [10:0]        base;
    logic [63:0]        pk_sum;

    // Stage 1: align and subtract
    assign dif = op_a.exp - op_b.exp;
    assign bal = {op_b.sig, 2'b00} >> dif[1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= {op_a.sig, 2'b00} - bal;
            ea_reg  <= op_a.exp;
        end
    end

    // Stage 2: renormalize, round and pack
    always_comb begin
        if (rem_reg[54]) begin
            sg = rem_reg[54:2];
            g  = rem_reg[1];
            st = rem_reg[0];
            e  = ea_reg;
        end else if (rem_reg[53]) begin
            sg = rem_reg[53:1];
            g  = rem_reg[0];
            st = 1'b0;
            e  = ea_reg - 13'sd1;
        end else begin
            sg = rem_reg[52:0];
            g  = 1'b0;
            st = 1'b0;
            e  = ea_reg - 13'sd2;
        end
        rnd    = g & (st | sg[0]);
        sum    = {1'b0, sg} + {53'b0, rnd};
        base   = 11'(e - 13'sd1);
        pk_sum = {1'b0, base, 52'b0} + {10'b0, sum};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= pk_sum[62:0];
        end
    end

    assign mag = mag_reg;

endmodule

// File: rtl/core/dnr_init.sv
// ============================================================================
// dnr_init - operand scaling, first estimate and dividend normalization
// Registers the operand words, forms 48/17 - (32/17)*d and, alongside,
// normalizes a subnormal dividend one leading-zero step per stage.
// ============================================================================
module dnr_init (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            take,
    input  logic [63:0]     dividend_bits,
    input  logic [63:0]     divisor_bits,
    output dnr_pkg::cell_t  cell_out
);

    logic                   v0_reg;
    dnr_pkg::fp_t           d0_reg;
    dnr_pkg::side_t         side0_reg;

    logic [dnr_pkg::INIT_LAT-1:0] vld_reg;
    dnr_pkg::fp_t           d_pipe_reg    [dnr_pkg::INIT_LAT];
    dnr_pkg::side_t         side_pipe_reg [dnr_pkg::INIT_LAT];

    logic [10:0]            e1;
    logic [10:0]            e2;
    logic [10:0]            e_new;
    logic [51:0]            frac_a;
    logic                   zero_res;
    dnr_pkg::fp_t           d_in;
    dnr_pkg::side_t         side_in;
    logic [62:0]            t_mag;
    logic [62:0]            x_mag;

    // Shift out one group of leading zeros when the top bits are all clear
    function automatic dnr_pkg::side_t norm_step(input dnr_pkg::side_t s,
                                                 input logic [5:0] amt);
        dnr_pkg::side_t r;
        logic [52:0]    top_mask;
        r        = s;
        top_mask = ~({53{1'b1}} >> amt);
        if ((s.a.sig != '0) && ((s.a.sig & top_mask) == '0)) begin
            r.a.sig = s.a.sig << amt;
            r.a.exp = s.a.exp - $signed({7'b0, amt});
        end
        return r;
    endfunction

    // Scale the operands and flag the results that bypass the multiply
    always_comb begin
        e1     = dividend_bits[62:52];
        e2     = divisor_bits[62:52];
        frac_a = dividend_bits[51:0];
        e_new  = (dividend_bits[62:0] == '0) ? 11'd0 : e1 + dnr_pkg::EXP_HALF - e2;
        zero_res = (dividend_bits[62:0] == '0) || (divisor_bits[62:0] == '0)
                   || ((e_new == '0) && (frac_a == '0));

        d_in.exp = $signed({2'b00, dnr_pkg::EXP_HALF});
        d_in.sig = {1'b1, divisor_bits[51:0]};

        side_in.sign     = dividend_bits[63] ^ divisor_bits[63];
        side_in.force_en = zero_res || (e_new == dnr_pkg::EXP_ALL_ONES);
        if (zero_res) begin
            side_in.force_mag = '0;
        end else if (frac_a == '0) begin
            side_in.force_mag = {dnr_pkg::EXP_ALL_ONES, 52'b0};
        end else begin
            side_in.force_mag = {dnr_pkg::EXP_ALL_ONES, 1'b1, frac_a[50:0]};
        end
        side_in.a.exp = (e_new == '0) ? 13'sd1 : $signed({2'b00, e_new});
        side_in.a.sig = {(e_new != '0), frac_a};
    end

    // Hold the accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg    <= d_in;
            side0_reg <= side_in;
        end
    end

    // First estimate: t = (32/17)*d, x = 48/17 - t
    dnr_fmul u_est_mul (
        .aclk (aclk),
        .en   (en),
        .op_a (dnr_pkg::C1),
        .op_b (d0_reg),
        .mag  (t_mag)
    );

    dnr_fsub u_est_sub (
        .aclk (aclk),
        .en   (en),
        .op_a (dnr_pkg::C0),
        .op_b (dnr_pkg::unpack_mag(t_mag)),
        .mag  (x_mag)
    );

    // Advance valid, divisor and normalized dividend beside the estimate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[dnr_pkg::INIT_LAT-2:0], v0_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_pipe_reg[0]    <= d0_reg;
            side_pipe_reg[0] <= norm_step(side0_reg, 6'(dnr_pkg::NORM_TOP));
            for (int k = 1; k < dnr_pkg::INIT_LAT; k++) begin
                d_pipe_reg[k]    <= d_pipe_reg[k-1];
                side_pipe_reg[k] <= norm_step(side_pipe_reg[k-1],
                                              6'(dnr_pkg::NORM_TOP >> k));
            end
        end
    end

    always_comb begin
        cell_out.valid = vld_reg[dnr_pkg::INIT_LAT-1];
        cell_out.d     = d_pipe_reg[dnr_pkg::INIT_LAT-1];
        cell_out.x     = dnr_pkg::unpack_mag(x_mag);
        cell_out.side  = side_pipe_reg[dnr_pkg::INIT_LAT-1];
    end

endmodule

// File: rtl/core/dnr_nr_cell.sv
// ============================================================================
// dnr_nr_cell - one Newton-Raphson step, x = x * (2 - d*x)
// Ten stages: multiply, subtract from two, multiply. Divisor, dividend data
// and valid move beside the arithmetic to the next cell.
// ============================================================================
module dnr_nr_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  dnr_pkg::cell_t  cell_in,
    output dnr_pkg::cell_t  cell_out
);

    logic [dnr_pkg::CELL_LAT-1:0] vld_reg;
    dnr_pkg::fp_t           d_pipe_reg    [dnr_pkg::CELL_LAT];
    dnr_pkg::side_t         side_pipe_reg [dnr_pkg::CELL_LAT];
    dnr_pkg::fp_t           x_pipe_reg    [dnr_pkg::X_LAT];

    logic [62:0]            t_mag;
    logic [62:0]            u_mag;
    logic [62:0]            x_mag;

    // t = d*x
    dnr_fmul u_dx_mul (
        .aclk (aclk),
        .en   (en),
        .op_a (cell_in.d),
        .op_b (cell_in.x),
        .mag  (t_mag)
    );

    // u = 2 - t
    dnr_fsub u_two_sub (
        .aclk (aclk),
        .en   (en),
        .op_a (dnr_pkg::TWO),
        .op_b (dnr_pkg::unpack_mag(t_mag)),
        .mag  (u_mag)
    );

    // x' = x*u
    dnr_fmul u_xu_mul (
        .aclk (aclk),
        .en   (en),
        .op_a (x_pipe_reg[dnr_pkg::X_LAT-1]),
        .op_b (dnr_pkg::unpack_mag(u_mag)),
        .mag  (x_mag)
    );

    // Advance valid beside the arithmetic
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[dnr_pkg::CELL_LAT-2:0], cell_in.valid};
        end
    end

    // Advance divisor, dividend data and the old estimate
    always_ff @(posedge aclk) begin
        if (en) begin
            d_pipe_reg[0]    <= cell_in.d;
            side_pipe_reg[0] <= cell_in.side;
            x_pipe_reg[0]    <= cell_in.x;
            for (int k = 1; k < dnr_pkg::CELL_LAT; k++) begin
                d_pipe_reg[k]    <= d_pipe_reg[k-1];
                side_pipe_reg[k] <= side_pipe_reg[k-1];
            end
            for (int k = 1; k < dnr_pkg::X_LAT; k++) begin
                x_pipe_reg[k] <= x_pipe_reg[k-1];
            end
        end
    end

    always_comb begin
        cell_out.valid = vld_reg[dnr_pkg::CELL_LAT-1];
        cell_out.d     = d_pipe_reg[dnr_pkg::CELL_LAT-1];
        cell_out.x     = dnr_pkg::unpack_mag(x_mag);
        cell_out.side  = side_pipe_reg[dnr_pkg::CELL_LAT-1];
    end

endmodule

// File: rtl/core/double_newton_raphson_divider_core.sv
// Throughput: one word per cycle while the skid stage is empty; the whole cell row stalls while it holds a word.
// Each Newton-Raphson cell is ten stages: two four-stage multiplies and a subtract.
// An output register plus a one-word skid stage stall the row only when both hold.
// Reset (aresetn low, synchronous) clears all valid flags, also those of output and skid; data is not reset.
// ============================================================================
// double_newton_raphson_divider_core - pipelined double divide
// Estimate stage, a row of Newton-Raphson cells, final dividend multiply,
// special-result override and the output register with skid stage.
// ============================================================================
module double_newton_raphson_divider_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_dividend_bits,
    input  logic [63:0] s_divisor_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_quotient_bits
);

    dnr_pkg::cell_t         link [dnr_pkg::ITERATIONS+1];

    logic                   en;
    logic                   take;
    logic                   out_free;

    logic [dnr_pkg::FMUL_LAT-1:0] fv_reg;
    dnr_pkg::side_t         fs_reg [dnr_pkg::FMUL_LAT];
    logic [62:0]            q_mag;
    logic [63:0]            fin_word;
    logic                   fin_valid;

    logic                   m_valid_reg;
    logic [63:0]            m_data_reg;
    logic                   skid_valid_reg;
    logic [63:0]            skid_data_reg;

    // Advance the whole row while the skid stage is empty
    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign take    = s_valid & en;

    dnr_init u_init (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .take          (take),
        .dividend_bits (s_dividend_bits),
        .divisor_bits  (s_divisor_bits),
        .cell_out      (link[0])
    );

    // Row of Newton-Raphson cells
    for (genvar i = 0; i < dnr_pkg::ITERATIONS; i++) begin : g_cell
        dnr_nr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (link[i]),
            .cell_out (link[i+1])
        );
    end

    // Quotient magnitude a*x
    dnr_fmul u_q_mul (
        .aclk (aclk),
        .en   (en),
        .op_a (link[dnr_pkg::ITERATIONS].side.a),
        .op_b (link[dnr_pkg::ITERATIONS].x),
        .mag  (q_mag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[dnr_pkg::FMUL_LAT-2:0], link[dnr_pkg::ITERATIONS].valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fs_reg[0] <= link[dnr_pkg::ITERATIONS].side;
            for (int k = 1; k < dnr_pkg::FMUL_LAT; k++) begin
                fs_reg[k] <= fs_reg[k-1];
            end
        end
    end

    // Override zero, infinite and NaN results, apply the sign
    assign fin_valid = fv_reg[dnr_pkg::FMUL_LAT-1];
    assign fin_word  = {fs_reg[dnr_pkg::FMUL_LAT-1].sign,
                        fs_reg[dnr_pkg::FMUL_LAT-1].force_en ?
                        fs_reg[dnr_pkg::FMUL_LAT-1].force_mag : q_mag};

    // Output register and skid stage
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= fin_valid;
            end
        end else if (fin_valid && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : fin_word;
        end else if (en) begin
            skid_data_reg <= fin_word;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_quotient_bits = m_data_reg;

endmodule

// File: rtl/core/dnr_checker.sv
// ============================================================================
// dnr_port_checker - port-level checks of the divider
// Watches the handshakes, counts words in flight and checks reset and stall
// behavior seen at the ports.
// ============================================================================
module dnr_port_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_dividend_bits,
    input  logic [63:0] s_divisor_bits,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_quotient_bits
);

    logic [7:0] cnt_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Track words accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_reg + {7'b0, in_acc} - {7'b0, out_acc};
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_dividend_bits)
                                && $stable(s_divisor_bits))
        else $error("stalled input word changed or dropped");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient_bits))
        else $error("stalled result word changed or dropped");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while output register empty");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != 8'd0)
        else $error("result word without an accepted input word");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output valid or input stalled after reset");

endmodule

bind double_newton_raphson_divider_core dnr_port_checker u_dnr_checker (.*);

// File: sim/dnr_checker.sv
// ============================================================================
// dnr_checker - scoreboard for the Newton-Raphson double divider
// Watches both channels and predicts each quotient word with host double
// arithmetic, one rounded operation per step. It compares every output word
// in order with the oldest predicted quotient.
// ============================================================================
module dnr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_dividend_bits,
    input  logic [63:0] s_divisor_bits,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_quotient_bits,
    output int          fail_count,
    output int          quotients_pending,
    output int          quotients_checked
);

    logic [63:0] quotient_queue[$];

    // Rescale both operands, refine the reciprocal, multiply by the dividend, then apply the sign
    function automatic logic [63:0] predict_quotient(input logic [63:0] num,
                                                     input logic [63:0] den);
        logic [62:0] num_mag;
        logic [62:0] den_mag;
        logic [10:0] exp_q;
        logic [63:0] num_scaled;
        logic [63:0] den_scaled;
        logic [63:0] mag_bits;
        real         a;
        real         d;
        real         t;
        real         x;
        real         q;
        num_mag    = num[62:0];
        den_mag    = den[62:0];
        exp_q      = (num_mag == '0) ? 11'd0
                     : num[62:52] - den[62:52] + dnr_pkg::EXP_HALF;
        num_scaled = {1'b0, exp_q, num[51:0]};
        den_scaled = {1'b0, dnr_pkg::EXP_HALF, den[51:0]};
        a = $bitstoreal(num_scaled);
        d = $bitstoreal(den_scaled);
        t = 1.88235294818878173828125 * d;
        x = 2.8235294818878173828125 - t;
        for (int i = 0; i < dnr_pkg::ITERATIONS; i++) begin
            t = d * x;
            t = 2.0 - t;
            x = x * t;
        end
        if (num_mag != '0 && den_mag != '0) begin
            q = a * x;
        end else begin
            q = 0.0;
        end
        mag_bits = $realtobits(q);
        return {num[63] ^ den[63], mag_bits[62:0]};
    endfunction

    assign quotients_pending = quotient_queue.size();

    // Predict on input words, compare on output words
    always @(posedge aclk) begin
        logic [63:0] want;
        if (!aresetn) begin
            quotient_queue.delete();
            fail_count        <= 0;
            quotients_checked <= 0;
        end else begin
            if (s_valid && s_ready) begin
                quotient_queue.push_back(predict_quotient(s_dividend_bits, s_divisor_bits));
            end
            if (m_valid && m_ready) begin
                quotients_checked <= quotients_checked + 1;
                if (quotient_queue.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("ERROR: unexpected quotient word %h", m_quotient_bits);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = quotient_queue.pop_front();
                    if (want !== m_quotient_bits) begin
                        if (fail_count < 10) begin
                            $display("ERROR: quotient_bits expected %h actual %h",
                                     want, m_quotient_bits);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/tb_top.sv
// ============================================================================
// tb_top - regression bench for the Newton-Raphson double divider
// Sends directed operand pairs, then random pairs in four phases of input idles
// and output stalls, with a long output hold-off in the first. The checker module
// scores every quotient word.
module tb_top;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_dividend_bits;
    logic [63:0] s_divisor_bits;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_quotient_bits;
    int          fail_count;
    int          quotients_pending;
    int          quotients_checked;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_req;
    int          hold_cnt;
    int          cycle_cnt;
    int          words_sent;

    double_newton_raphson_divider_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_dividend_bits (s_dividend_bits),
        .s_divisor_bits  (s_divisor_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quotient_bits (m_quotient_bits)
    );

    dnr_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_dividend_bits   (s_dividend_bits),
        .s_divisor_bits    (s_divisor_bits),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_quotient_bits   (m_quotient_bits),
        .fail_count        (fail_count),
        .quotients_pending (quotients_pending),
        .quotients_checked (quotients_checked)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Stall the output at random, or hold it off for a long stretch on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req && hold_cnt == 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= 400;
        end else if (hold_cnt > 1) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            m_ready  <= ($urandom_range(99) >= recv_stall_pct);
            hold_cnt <= (hold_cnt == 1 && hold_req) ? 1 : 0;
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 2000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Random double: mostly moderate exponents, some raw patterns and zeros
    function automatic logic [63:0] random_double();
        int          pick;
        logic [10:0] exp_f;
        pick  = $urandom_range(99);
        exp_f = 11'($urandom_range(1223, 823));
        if (pick < 6) begin
            return {1'($urandom_range(1)), 63'd0};
        end else if (pick < 18) begin
            return {$urandom, $urandom};
        end
        return {1'($urandom), exp_f, 20'($urandom), $urandom};
    endfunction

    // Offer one word and hold it until it is accepted
    task automatic send_word(input logic [63:0] num, input logic [63:0] den);
        logic rdy;
        s_valid         <= 1'b1;
        s_dividend_bits <= num;
        s_divisor_bits  <= den;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        words_sent++;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
            @(posedge aclk);
        end
    endtask

    initial begin
        logic [63:0] directed_num[16];
        logic [63:0] directed_den[16];
        int          watchdog;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_dividend_bits = '0;
        s_divisor_bits  = '0;
        hold_req        = 1'b0;
        words_sent      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zeros of both signs, extremes, wrapping exponents, denormals, specials
        directed_num = '{64'h0000000000000000, 64'h8000000000000000, 64'h3FF0000000000000,
                         64'hFFFFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 64'h0010000000000000,
                         64'h000FFFFFFFFFFFFF, 64'h7FF0000000000000, 64'h7FF8000000000000,
                         64'h4008000000000000, 64'hC01C000000000000, 64'h3FF0000000000001,
                         64'h0000000000000001, 64'h7FFFFFFFFFFFFFFF, 64'h4000000000000000,
                         64'h3FEFFFFFFFFFFFFF};
        directed_den = '{64'h3FF0000000000000, 64'h3FF0000000000000, 64'h8000000000000000,
                         64'h0000000000000000, 64'h0010000000000000, 64'h7FEFFFFFFFFFFFFF,
                         64'h000FFFFFFFFFFFFF, 64'h3FF0000000000000, 64'h3FF8000000000000,
                         64'h4008000000000000, 64'h400FFFFFFFFFFFFF, 64'hBFF0000000000000,
                         64'h7FF0000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001,
                         64'h3FE0000000000000};
        foreach (directed_num[i]) send_word(directed_num[i], directed_den[i]);

        // Four phases of random operands with different input idle and output stall rates
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 86 : (phase == 3) ? 21 : 0;
            recv_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 21 : 0;
            for (int n = 0; n < 185; n++) begin
                // Long output hold-off while input keeps coming
                hold_req <= (phase == 0 && n >= 20 && n < 100);
                send_word(random_double(), random_double());
            end
            hold_req <= 1'b0;
        end
        s_valid <= 1'b0;

        // Drain the pipeline
        watchdog = 0;
        while (quotients_pending != 0 && watchdog < 100000) begin
            @(posedge aclk);
            watchdog++;
        end
        repeat (80) @(posedge aclk);

        $display("Sent %0d operand words, checked %0d quotient words across four idling phases",
                 words_sent, quotients_checked);
        $display("Covered zeros, denormals, specials, exponent wrap and a long output hold-off");
        if (fail_count == 0 && quotients_pending == 0) begin
            $display("Regression PASS");
        end else begin
            if (quotients_pending != 0) begin
                $display("ERROR: %0d quotient words never arrived", quotients_pending);
            end
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/dnr_pkg.sv
rtl/core/dnr_fmul.sv
rtl/core/dnr_fsub.sv
rtl/core/dnr_init.sv
rtl/core/dnr_nr_cell.sv
rtl/core/double_newton_raphson_divider_core.sv
rtl/core/dnr_checker.sv
sim/dnr_checker.sv
sim/tb_top.sv
